@@ rtl/rrts_pkg.sv @@
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// slot states, event modes, status codes and the cell command bundle
// no dependencies
`default_nettype none

package rrts_pkg;

  localparam int unsigned NUM_THREADS = 16;
  localparam int unsigned ID_W        = $clog2(NUM_THREADS);
  localparam int unsigned USED_W      = $clog2(NUM_THREADS + 1);
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned DUR_W       = 32;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    SLOT_READY    = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_SLEEPING = 2'd2,
    SLOT_DEAD     = 2'd3
  } slot_state_t;

  localparam logic [2:0] MODE_SPAWN   = 3'd0;
  localparam logic [2:0] MODE_YIELD   = 3'd1;
  localparam logic [2:0] MODE_SLEEP   = 3'd2;
  localparam logic [2:0] MODE_EXIT    = 3'd3;
  localparam logic [2:0] MODE_PREEMPT = 3'd4;

  localparam logic [2:0] STATUS_SWITCHED = 3'd0;
  localparam logic [2:0] STATUS_NONE     = 3'd1;
  localparam logic [2:0] STATUS_SPAWNED  = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_IGNORED  = 3'd4;

  // command broadcast from the sequencer to every cell
  typedef struct packed {
    logic  spawn;
    logic  sleep;
    logic  retire;
    logic  wake;
    logic  inject;
    logic  clr_tok;
    logic  adv;
    logic  set_run;
    logic  demote;
    id_t   sel_a;
    id_t   sel_b;
    used_t used;
    time_t now;
    time_t wake_val;
  } rrts_cmd_t;

endpackage

`default_nettype wire

@@ rtl/rrts_in_if.sv @@
// rrts_in_if: event channel of the scheduler, valid/ready with payload
// depends on rrts_pkg
`default_nettype none

interface rrts_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  rrts_pkg::time_t             now_us;
  logic [rrts_pkg::DUR_W-1:0]  sleep_duration;

  modport source (output valid, output mode, output now_us, output sleep_duration,
                  input ready);
  modport sink   (input valid, input mode, input now_us, input sleep_duration,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rrts_out_if.sv @@
// rrts_out_if: result channel of the scheduler, valid/ready with payload
// depends on rrts_pkg
`default_nettype none

interface rrts_out_if;
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  rrts_pkg::id_t thread_id;
  logic          previous_valid;
  rrts_pkg::id_t previous_thread;

  modport source (output valid, output status, output thread_id, output previous_valid,
                  output previous_thread, input ready);
  modport sink   (input valid, input status, input thread_id, input previous_valid,
                  input previous_thread, output ready);
endinterface

`default_nettype wire

@@ rtl/rrts_cell.sv @@
// rrts_cell: one thread slot, holding its state, wake time and search token
// the token is handed to the next cell of the ring on each advance
// depends on rrts_pkg
`default_nettype none

module rrts_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rrts_pkg::rrts_cmd_t cmd,
  input  wire                 tok_in,
  output logic                tok_out,
  output logic                hit
);
  import rrts_pkg::*;

  slot_state_t st_r, st_nxt;
  time_t       wt_r, wt_nxt;
  logic        tok_r, tok_nxt;
  logic        match_a, match_b, used;

  assign match_a = (cmd.sel_a == ID_W'(IDX));
  assign match_b = (cmd.sel_b == ID_W'(IDX));
  assign used    = (USED_W'(IDX) < cmd.used);

  always_comb begin
    st_nxt = st_r;
    wt_nxt = wt_r;
    priority if (cmd.spawn && match_a) begin
      st_nxt = SLOT_READY;
      wt_nxt = '0;
    end else if (cmd.sleep && match_a) begin
      st_nxt = SLOT_SLEEPING;
      wt_nxt = cmd.wake_val;
    end else if (cmd.retire && match_a) begin
      st_nxt = SLOT_DEAD;
    end else if (cmd.wake && st_r == SLOT_SLEEPING && cmd.now >= wt_r) begin
      st_nxt = SLOT_READY;
    end else if (cmd.set_run && match_a) begin
      st_nxt = SLOT_RUNNING;
    end else if (cmd.demote && match_b && st_r == SLOT_RUNNING) begin
      st_nxt = SLOT_READY;
    end else begin
      st_nxt = st_r;
    end
  end

  always_comb begin
    priority if (cmd.clr_tok) begin
      tok_nxt = 1'b0;
    end else if (cmd.inject) begin
      tok_nxt = match_a;
    end else if (cmd.adv) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    wt_r <= wt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign hit     = tok_r && used && (st_r == SLOT_READY);

endmodule

`default_nettype wire

@@ rtl/round_robin_thread_scheduler.sv @@
// round_robin_thread_scheduler: top level, event sequencer and ring of slot cells
// depends on rrts_pkg, rrts_in_if, rrts_out_if, rrts_cell
//
//   channel   role     transfer when            payload
//   in_ch     sink     valid && ready           mode, now_us, sleep_duration
//   out_ch    source   valid && ready           status, thread_id, previous_valid,
//                                               previous_thread
//
// spawn, ignored and full events answer in the cycle after their transfer
// scheduling events answer after one wake pass, then the search token walks the cell
// ring one slot per cycle until a ready slot holds it, or with status none once every
// slot has been passed
// one event at a time; a new event is taken once the result register is free
// reset: synchronous, active low; slot contents are written by spawn before use
`default_nettype none

module round_robin_thread_scheduler (
  input wire         clk,
  input wire         rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAKE = 3'b010,
    S_SCAN = 3'b100
  } fsm_t;

  fsm_t      state_r, state_nxt;
  id_t       cur_r, cur_nxt;
  logic      cv_r, cv_nxt;
  used_t     used_r, used_nxt;
  time_t     now_r, now_nxt;
  id_t       pos_r, pos_nxt;
  id_t       cnt_r, cnt_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  id_t        out_tid_r;
  logic       out_pv_r;
  id_t        out_pt_r;

  logic       res_load;
  logic [2:0] res_status;
  id_t        res_tid;
  logic       res_pv;
  id_t        res_pt;

  rrts_cmd_t  cmd;
  logic       in_ready, acc, any_hit;
  logic [TIME_W:0] wake_sum;
  time_t      wake_sat;
  id_t        start;
  used_t      cur_inc;

  logic [NUM_THREADS-1:0] tok_w;
  logic [NUM_THREADS-1:0] hit_w;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  assign wake_sum = {1'b0, in_ch.now_us} + {{(TIME_W + 1 - DUR_W){1'b0}}, in_ch.sleep_duration};
  assign wake_sat = wake_sum[TIME_W] ? {TIME_W{1'b1}} : wake_sum[TIME_W-1:0];

  assign cur_inc = {1'b0, cur_r} + USED_W'(1);
  assign start   = (cv_r && cur_inc < used_r) ? cur_inc[ID_W-1:0] : '0;
  assign any_hit = |hit_w;

  always_comb begin
    cmd          = '0;
    cmd.used     = used_r;
    cmd.now      = now_r;
    cmd.wake_val = wake_sat;
    cmd.sel_b    = cur_r;
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    cv_nxt       = cv_r;
    used_nxt     = used_r;
    now_nxt      = now_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    res_load     = 1'b0;
    res_status   = STATUS_IGNORED;
    res_tid      = '0;
    res_pv       = 1'b0;
    res_pt       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          now_nxt = in_ch.now_us;
          unique case (in_ch.mode)
            MODE_SPAWN: begin
              res_load = 1'b1;
              if (used_r == USED_W'(NUM_THREADS)) begin
                res_status = STATUS_FULL;
              end else begin
                cmd.spawn  = 1'b1;
                cmd.sel_a  = used_r[ID_W-1:0];
                res_status = STATUS_SPAWNED;
                res_tid    = used_r[ID_W-1:0];
                used_nxt   = used_r + USED_W'(1);
              end
            end
            MODE_YIELD: begin
              state_nxt = S_WAKE;
            end
            MODE_SLEEP: begin
              if (cv_r) begin
                cmd.sleep = 1'b1;
                cmd.sel_a = cur_r;
                state_nxt = S_WAKE;
              end else begin
                res_load = 1'b1;
              end
            end
            MODE_EXIT: begin
              if (cv_r) begin
                cmd.retire = 1'b1;
                cmd.sel_a  = cur_r;
                state_nxt  = S_WAKE;
              end else begin
                res_load = 1'b1;
              end
            end
            MODE_PREEMPT: begin
              if (cv_r) begin
                state_nxt = S_WAKE;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_WAKE: begin
        cmd.wake   = 1'b1;
        cmd.inject = 1'b1;
        cmd.sel_a  = start;
        pos_nxt    = start;
        cnt_nxt    = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (any_hit) begin
          cmd.set_run = 1'b1;
          cmd.sel_a   = pos_r;
          cmd.demote  = cv_r && (cur_r != pos_r);
          cmd.clr_tok = 1'b1;
          cur_nxt     = pos_r;
          cv_nxt      = 1'b1;
          res_load    = 1'b1;
          res_status  = STATUS_SWITCHED;
          res_tid     = pos_r;
          res_pv      = cv_r;
          res_pt      = cv_r ? cur_r : '0;
          state_nxt   = S_IDLE;
        end else if (cnt_r == ID_W'(NUM_THREADS - 1)) begin
          cmd.clr_tok = 1'b1;
          res_load    = 1'b1;
          res_status  = STATUS_NONE;
          state_nxt   = S_IDLE;
        end else begin
          cmd.adv = 1'b1;
          pos_nxt = (pos_r == ID_W'(NUM_THREADS - 1)) ? '0 : pos_r + ID_W'(1);
          cnt_nxt = cnt_r + ID_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      cv_r    <= 1'b0;
      used_r  <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cv_r    <= cv_nxt;
      used_r  <= used_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_tid_r    <= res_tid;
      out_pv_r     <= res_pv;
      out_pt_r     <= res_pt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.thread_id       = out_tid_r;
  assign out_ch.previous_valid  = out_pv_r;
  assign out_ch.previous_thread = out_pt_r;

  // ring of slot cells
  for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
    rrts_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tok_in  (tok_w[(i + NUM_THREADS - 1) % NUM_THREADS]),
      .tok_out (tok_w[i]),
      .hit     (hit_w[i])
    );
  end

endmodule

`default_nettype wire
